@@ rtl/gbs_pkg.sv @@
// Package with the payload types, chain token types and shared compare logic.
package gbs_pkg;

	localparam int unsigned FieldW = 14;
	localparam int unsigned CoordW = 16;
	localparam int unsigned AreaW = 2 * CoordW;
	localparam int unsigned IdxW = 11;

	localparam logic [15:0] ThrReset = 16'd42598;
	localparam logic [7:0] RegThreshold = 8'd0;
	localparam logic [7:0] RegAgnostic = 8'd1;

	typedef struct packed {
		logic start_frame;
		logic [FieldW-1:0] box_left;
		logic [FieldW-1:0] box_top;
		logic [FieldW-1:0] box_width;
		logic [FieldW-1:0] box_height;
		logic [7:0] class_label;
	} in_t;

	typedef struct packed {
		logic keep;
		logic [15:0] box_index;
		logic store_full;
	} out_t;

	typedef struct packed {
		logic [CoordW-1:0] l;
		logic [CoordW-1:0] t;
		logic [CoordW-1:0] r;
		logic [CoordW-1:0] b;
		logic [7:0] label;
		logic [AreaW-1:0] area;
	} box_t;

	// Query token travelling down the chain, with the pending overlap of the
	// previous cell, registered there and compared in the next cell.
	typedef struct packed {
		logic valid;
		box_t box;
		logic keep;
		logic pend;
		logic [AreaW-1:0] inter;
		logic [AreaW:0] uni;
	} tok_t;

	typedef struct packed {
		logic en;
		logic [IdxW-1:0] idx;
		box_t box;
	} wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	function automatic logic overlap_hit(input tok_t tk, input logic [15:0] thr);
		logic [AreaW+16:0] lhs;
		logic [AreaW+16:0] rhs;
		lhs = {1'b0, tk.inter, 16'b0};
		rhs = thr * tk.uni;
		return tk.pend && (lhs > rhs);
	endfunction

endpackage

@@ rtl/gbs_cell.sv @@
// One cell of the chain: holds a kept box and tests the passing query against it.
module gbs_cell #(
	parameter int unsigned IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input gbs_pkg::tok_t tok_in,
	input gbs_pkg::wr_t wr,
	input logic [gbs_pkg::IdxW-1:0] count,
	input logic [15:0] thr,
	input logic agnostic,
	output gbs_pkg::tok_t tok_out
);
	import gbs_pkg::*;

	box_t kept_q;
	tok_t tok_q;
	logic active;
	logic [CoordW-1:0] lx, hx, ly, hy, wx, wy;
	logic [AreaW-1:0] inter;

	assign active = (IdxW'(IDX) < count) && (agnostic || (kept_q.label == tok_in.box.label));

	always_comb begin
		lx = (tok_in.box.l > kept_q.l) ? tok_in.box.l : kept_q.l;
		hx = (tok_in.box.r < kept_q.r) ? tok_in.box.r : kept_q.r;
		ly = (tok_in.box.t > kept_q.t) ? tok_in.box.t : kept_q.t;
		hy = (tok_in.box.b < kept_q.b) ? tok_in.box.b : kept_q.b;
		wx = (hx > lx) ? hx - lx : '0;
		wy = (hy > ly) ? hy - ly : '0;
		inter = wx * wy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.box <= tok_in.box;
			tok_q.keep <= tok_in.keep & ~overlap_hit(tok_in, thr);
			tok_q.pend <= active;
			tok_q.inter <= inter;
			tok_q.uni <= {1'b0, tok_in.box.area} + {1'b0, kept_q.area} - {1'b0, inter};
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == IdxW'(IDX))) begin
			kept_q <= wr.box;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ rtl/greedy_box_suppression.sv @@
// Top level: chain of kept-box cells with query front end and result register.
// Each box passes down a chain of MAX_KEPT cells, one cell per clock. Its result is
// registered in the keep register and then enters the output register; the input opens
// again in the same cycle, so the block takes no new box until the last has finished.
// One box is in flight at a time; while the previous result still waits in the output
// register, the finished box waits too, so a receiver stall delays the next box.
// Boxes must arrive sorted by descending score.
module greedy_box_suppression #(
	parameter int unsigned MAX_KEPT = 64,
	parameter int unsigned COORD_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input gbs_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output gbs_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [15:0] cfg_data
);
	import gbs_pkg::*;

	localparam logic [CoordW-1:0] CoordMax = CoordW'((32'd1 << COORD_BITS) - 32'd1);

	state_t state_q, state_d;
	tok_t tok [0:MAX_KEPT];
	tok_t tok0_q;
	wr_t wr;
	logic [15:0] thr_q;
	logic agn_q;
	logic [IdxW-1:0] count_q;
	logic [15:0] pos_q;
	logic keep_q;
	logic out_valid_q;
	out_t out_q;
	logic in_acc, finish_go, do_store;
	box_t qbox;
	logic [CoordW:0] er, eb;
	logic [CoordW-1:0] ql, qt;

	always_comb begin
		ql = {2'b0, in_data.box_left} & CoordMax;
		qt = {2'b0, in_data.box_top} & CoordMax;
		er = {1'b0, ql} + {1'b0, ({2'b0, in_data.box_width} & CoordMax)};
		eb = {1'b0, qt} + {1'b0, ({2'b0, in_data.box_height} & CoordMax)};
		qbox.l = ql;
		qbox.t = qt;
		qbox.r = (er > {1'b0, CoordMax}) ? CoordMax : er[CoordW-1:0];
		qbox.b = (eb > {1'b0, CoordMax}) ? CoordMax : eb[CoordW-1:0];
		qbox.label = in_data.class_label;
		qbox.area = (qbox.r - qbox.l) * (qbox.b - qbox.t);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RUN;
			ST_RUN: if (tok[MAX_KEPT].valid) state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign in_acc = in_valid && in_ready;
	assign do_store = finish_go && keep_q && (count_q < IdxW'(MAX_KEPT));
	assign cfg_ready = 1'b1;

	always_comb begin
		wr.en = do_store;
		wr.idx = count_q;
		wr.box = tok0_q.box;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= ThrReset;
			agn_q <= 1'b0;
			count_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
			tok0_q <= '0;
		end else begin
			state_q <= state_d;
			tok0_q.valid <= in_acc;
			if (in_acc) begin
				tok0_q.box <= qbox;
				tok0_q.keep <= 1'b1;
				tok0_q.pend <= 1'b0;
				tok0_q.inter <= '0;
				tok0_q.uni <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegThreshold) thr_q <= cfg_data;
				else if (cfg_index == RegAgnostic) agn_q <= cfg_data[0];
			end
			if (in_acc && in_data.start_frame) begin
				count_q <= '0;
				pos_q <= '0;
			end
			if (finish_go) begin
				if (do_store) count_q <= count_q + 1'b1;
				if (pos_q != 16'hFFFF) pos_q <= pos_q + 1'b1;
			end
			if (finish_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_KEPT].valid) begin
			keep_q <= tok[MAX_KEPT].keep & ~overlap_hit(tok[MAX_KEPT], thr_q);
		end
		if (finish_go) begin
			out_q.keep <= keep_q;
			out_q.box_index <= pos_q;
			out_q.store_full <= keep_q && (count_q >= IdxW'(MAX_KEPT));
		end
	end

	// The front register holds the query box for the whole pass and feeds it to the chain
	// as a token whose valid bit is a one-cycle strobe.
	always_comb begin
		tok[0] = tok0_q;
	end

	for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
		gbs_cell #(.IDX(k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(tok[k]),
			.wr(wr),
			.count(count_q),
			.thr(thr_q),
			.agnostic(agn_q),
			.tok_out(tok[k+1])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ rtl/gbs_checker.sv @@
// Port checker for the suppression block and its bind.
module gbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input gbs_pkg::out_t out_data,
	input logic out_valid,
	input logic out_ready
);
	import gbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while a box is in flight");

	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.store_full && !out_data.keep))
		else $error("store_full flagged on a suppressed box");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared without passing the chain");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_data(out_data),
	.out_valid(out_valid),
	.out_ready(out_ready)
);
